[rtl/cbra_pkg.sv]
// Shared types, codes and defaults of the chained bitmap range allocator.
package cbra_pkg;

  localparam int DEF_MAX_SLOTS = 1024;
  localparam logic [10:0] RESET_LENGTH = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_CNT  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_BAD_START = 2'd3;

  localparam int MARK_ALLOC = 0;
  localparam int MARK_CHAIN = 1;

  localparam logic [3:0] DP_NOP        = 4'd0;
  localparam logic [3:0] DP_CLEAR      = 4'd1;
  localparam logic [3:0] DP_LOAD       = 4'd2;
  localparam logic [3:0] DP_STATUS     = 4'd3;
  localparam logic [3:0] DP_SCAN_INIT  = 4'd4;
  localparam logic [3:0] DP_SCAN_STEP  = 4'd5;
  localparam logic [3:0] DP_MARK_INIT  = 4'd6;
  localparam logic [3:0] DP_MARK_STEP  = 4'd7;
  localparam logic [3:0] DP_HINT_SET   = 4'd8;
  localparam logic [3:0] DP_HINT_STEP  = 4'd9;
  localparam logic [3:0] DP_WALK_INIT  = 4'd10;
  localparam logic [3:0] DP_WALK_STEP  = 4'd11;
  localparam logic [3:0] DP_RESULT     = 4'd12;

  typedef struct packed {
    logic        op;
    logic [10:0] slot_count;
    logic [9:0]  start_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  granted_start;
    logic [10:0] free_slots;
  } rsp_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic count_zero;
    logic count_over;
    logic start_over;
    logic scan_fail;
    logic scan_found;
    logic mark_last;
    logic at_hint;
    logic hint_end;
    logic slot_used;
    logic walk_end;
  } dp_sts_t;

endpackage

[rtl/chained_bitmap_range_allocator_unit.sv]
// Alloc scans from the hint and then marks each granted slot; when the run starts at the hint,
// the hint then moves past used slots until it finds a free slot or reaches the length. A
// search fails when the run would pass the length; free walks the chain from the start slot;
// zero counts, oversize counts and bad starts are rejected before the search. One item is in work
// at a time, set by the single mark memory port. Reset and every length write start a
// clearing pass over all MAX_SLOTS slots with no item accepted; the result register frees input.
module chained_bitmap_range_allocator_unit #(
  parameter int MAX_SLOTS = cbra_pkg::DEF_MAX_SLOTS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_wdata,
  input  logic           req_valid,
  output logic           req_stall,
  input  cbra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cbra_pkg::rsp_t rsp
);

  cbra_pkg::dp_cmd_t cmd;
  cbra_pkg::dp_sts_t sts;

  cbra_dpath #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

  cbra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

endmodule

[rtl/cbra_dpath.sv]
// Datapath of the allocator: slot mark memory, scan pointers, counters and result register.
module cbra_dpath #(
  parameter int MAX_SLOTS = cbra_pkg::DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata,
  input  cbra_pkg::req_t    req,
  input  cbra_pkg::dp_cmd_t cmd,
  output cbra_pkg::dp_sts_t sts,
  output cbra_pkg::rsp_t    rsp
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CW    = (CNT_W > 11 ? CNT_W : 11) + 1;

  logic [1:0]       mem [MAX_SLOTS];
  logic [1:0]       rd_data;
  logic             mem_we;
  logic [1:0]       mem_wd;

  logic [CNT_W-1:0] p;
  logic [CNT_W-1:0] run_start;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] hint;
  logic [CNT_W-1:0] length;
  logic [CNT_W-1:0] free_total;
  logic [CNT_W-1:0] granted;
  logic [1:0]       res_status;
  cbra_pkg::req_t   item;

  logic [31:0]      cfg32;
  logic [31:0]      rst32;
  logic [31:0]      len32;
  logic [CNT_W-1:0] len_new;
  logic [CW-1:0]    ft_sub;
  logic [CW-1:0]    start_x;
  logic [CW-1:0]    count_x;
  logic [31:0]      granted32;
  logic [31:0]      free32;

  always_comb begin
    cfg32 = 32'(cfg_wdata);
    rst32 = 32'(cbra_pkg::RESET_LENGTH);
    len32 = rst ? rst32 : cfg32;
    if (len32 == 32'd0) begin
      len32 = 32'd1;
    end else if (len32 > 32'(MAX_SLOTS)) begin
      len32 = 32'(MAX_SLOTS);
    end
    len_new = len32[CNT_W-1:0];
  end

  assign start_x = CW'(item.start_slot);
  assign count_x = CW'(item.slot_count);
  assign ft_sub  = CW'(free_total) - count_x;

  always_comb begin
    sts.clr_last   = (p == CNT_W'(MAX_SLOTS - 1));
    sts.op_free    = (item.op == cbra_pkg::OP_FREE);
    sts.count_zero = (item.slot_count == 11'd0);
    sts.count_over = (count_x > CW'(free_total)) || (count_x > CW'(length));
    sts.start_over = (start_x >= CW'(length));
    sts.scan_fail  = (CW'(run_start) + count_x) > CW'(length);
    sts.scan_found = !rd_data[cbra_pkg::MARK_ALLOC] && (CW'(run_len) + CW'(1) == count_x);
    sts.mark_last  = (CW'(run_len) + CW'(1) == count_x);
    sts.at_hint    = (run_start == hint);
    sts.hint_end   = (p >= length);
    sts.slot_used  = rd_data[cbra_pkg::MARK_ALLOC];
    sts.walk_end   = !rd_data[cbra_pkg::MARK_CHAIN] || (CW'(p) + CW'(1) == CW'(length));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wd = 2'b00;
    case (cmd.op)
      cbra_pkg::DP_CLEAR: begin
        mem_we = 1'b1;
      end
      cbra_pkg::DP_MARK_STEP: begin
        mem_we = 1'b1;
        mem_wd[cbra_pkg::MARK_ALLOC] = 1'b1;
        mem_wd[cbra_pkg::MARK_CHAIN] = !sts.mark_last;
      end
      cbra_pkg::DP_WALK_STEP: begin
        mem_we = 1'b1;
        mem_wd[cbra_pkg::MARK_CHAIN] = rd_data[cbra_pkg::MARK_CHAIN];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[p[IDX_W-1:0]] <= mem_wd;
    end
    rd_data <= mem[p[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      length     <= len_new;
      free_total <= len_new;
      hint       <= '0;
      p          <= '0;
    end else begin
      case (cmd.op)
        cbra_pkg::DP_CLEAR: begin
          p <= p + CNT_W'(1);
        end
        cbra_pkg::DP_LOAD: begin
          item       <= req;
          res_status <= cbra_pkg::ST_OK;
          granted    <= '0;
        end
        cbra_pkg::DP_STATUS: begin
          res_status <= cmd.code;
        end
        cbra_pkg::DP_SCAN_INIT: begin
          p         <= hint;
          run_start <= hint;
          run_len   <= '0;
        end
        cbra_pkg::DP_SCAN_STEP: begin
          if (rd_data[cbra_pkg::MARK_ALLOC]) begin
            run_start <= p + CNT_W'(1);
            run_len   <= '0;
          end else begin
            run_len <= run_len + CNT_W'(1);
          end
          p <= p + CNT_W'(1);
        end
        cbra_pkg::DP_MARK_INIT: begin
          p       <= run_start;
          run_len <= '0;
        end
        cbra_pkg::DP_MARK_STEP: begin
          p       <= p + CNT_W'(1);
          run_len <= run_len + CNT_W'(1);
          if (sts.mark_last) begin
            free_total <= ft_sub[CNT_W-1:0];
            granted    <= run_start;
          end
        end
        cbra_pkg::DP_HINT_SET: begin
          hint <= p;
        end
        cbra_pkg::DP_HINT_STEP: begin
          p <= p + CNT_W'(1);
        end
        cbra_pkg::DP_WALK_INIT: begin
          p <= start_x[CNT_W-1:0];
        end
        cbra_pkg::DP_WALK_STEP: begin
          if (free_total < length) begin
            free_total <= free_total + CNT_W'(1);
          end
          p <= p + CNT_W'(1);
          if (sts.walk_end && (start_x < CW'(hint))) begin
            hint <= start_x[CNT_W-1:0];
          end
        end
        default: begin
          p <= p;
        end
      endcase
    end
  end

  assign granted32 = 32'(granted);
  assign free32    = 32'(free_total);

  always_ff @(posedge clk) begin
    if (cmd.op == cbra_pkg::DP_RESULT) begin
      rsp.status        <= res_status;
      rsp.granted_start <= granted32[9:0];
      rsp.free_slots    <= free32[10:0];
    end
  end

endmodule

[rtl/cbra_ctrl.sv]
// Controller of the allocator: sequences clearing, search, marking, hint update and chain walk.
module cbra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  cbra_pkg::dp_sts_t sts,
  output cbra_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_EV = 4'd4;
  localparam logic [3:0] S_MARK    = 4'd5;
  localparam logic [3:0] S_HINT_RD = 4'd6;
  localparam logic [3:0] S_HINT_EV = 4'd7;
  localparam logic [3:0] S_WALK_RD = 4'd8;
  localparam logic [3:0] S_WALK_EV = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rsp_free;

  assign req_stall = rst || (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd.op     = cbra_pkg::DP_NOP;
    cmd.code   = cbra_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.op = cbra_pkg::DP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = cbra_pkg::DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op_free) begin
          if (sts.start_over) begin
            cmd.op     = cbra_pkg::DP_STATUS;
            cmd.code   = cbra_pkg::ST_BAD_START;
            state_next = S_DONE;
          end else begin
            cmd.op     = cbra_pkg::DP_WALK_INIT;
            state_next = S_WALK_RD;
          end
        end else if (sts.count_zero) begin
          cmd.op     = cbra_pkg::DP_STATUS;
          cmd.code   = cbra_pkg::ST_ZERO_CNT;
          state_next = S_DONE;
        end else if (sts.count_over) begin
          cmd.op     = cbra_pkg::DP_STATUS;
          cmd.code   = cbra_pkg::ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          cmd.op     = cbra_pkg::DP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_fail) begin
          cmd.op     = cbra_pkg::DP_STATUS;
          cmd.code   = cbra_pkg::ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.scan_found) begin
          cmd.op     = cbra_pkg::DP_MARK_INIT;
          state_next = S_MARK;
        end else begin
          cmd.op     = cbra_pkg::DP_SCAN_STEP;
          state_next = S_SCAN_RD;
        end
      end
      S_MARK: begin
        cmd.op = cbra_pkg::DP_MARK_STEP;
        if (sts.mark_last) begin
          state_next = sts.at_hint ? S_HINT_RD : S_DONE;
        end
      end
      S_HINT_RD: begin
        if (sts.hint_end) begin
          cmd.op     = cbra_pkg::DP_HINT_SET;
          state_next = S_DONE;
        end else begin
          state_next = S_HINT_EV;
        end
      end
      S_HINT_EV: begin
        if (sts.slot_used) begin
          cmd.op     = cbra_pkg::DP_HINT_STEP;
          state_next = S_HINT_RD;
        end else begin
          cmd.op     = cbra_pkg::DP_HINT_SET;
          state_next = S_DONE;
        end
      end
      S_WALK_RD: begin
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        cmd.op = cbra_pkg::DP_WALK_STEP;
        if (sts.walk_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          cmd.op     = cbra_pkg::DP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[verif/tb_chained_bitmap_range_allocator_unit.sv]
// Self-checking testbench for the chained bitmap range allocator: directed table, random phases.
module tb_chained_bitmap_range_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] IDLE_NONE = 2'd0;
  localparam logic [1:0] IDLE_SRC  = 2'd1;
  localparam logic [1:0] IDLE_RCV  = 2'd2;
  localparam logic [1:0] IDLE_BOTH = 2'd3;

  typedef struct packed {
    logic        is_cfg;
    logic [10:0] cfg_len;
    logic        op;
    logic [10:0] cnt;
    logic [9:0]  start;
    logic        typed;
    logic [1:0]  st;
    logic [9:0]  gs;
    logic [10:0] fr;
  } row_t;

  typedef struct packed {
    logic [10:0] len;
    logic [1:0]  mode;
    logic [9:0]  items;
  } phase_t;

  typedef struct packed {
    logic           op;
    cbra_pkg::rsp_t r;
  } pending_t;

  localparam int PLAN_ROWS = 26;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{0, 0,    cbra_pkg::OP_ALLOC, 0,    0,    1, cbra_pkg::ST_ZERO_CNT,  0, 1024},
    '{0, 0,    cbra_pkg::OP_ALLOC, 2047, 0,    1, cbra_pkg::ST_NO_SPACE,  0, 1024},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1025, 1023, 1, cbra_pkg::ST_NO_SPACE,  0, 1024},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1024, 0,    1, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1,    0,    1, cbra_pkg::ST_NO_SPACE,  0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    1023, 1, cbra_pkg::ST_OK,        0, 1},
    '{0, 0,    cbra_pkg::OP_FREE,  2047, 0,    1, cbra_pkg::ST_OK,        0, 1024},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{1, 0,    cbra_pkg::OP_ALLOC, 0,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1,    0,    1, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1,    0,    1, cbra_pkg::ST_NO_SPACE,  0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    1,    1, cbra_pkg::ST_BAD_START, 0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    1023, 1, cbra_pkg::ST_BAD_START, 0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    0,    1, cbra_pkg::ST_OK,        0, 1},
    '{1, 2047, cbra_pkg::OP_ALLOC, 0,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 1024, 0,    1, cbra_pkg::ST_OK,        0, 0},
    '{1, 8,    cbra_pkg::OP_ALLOC, 0,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 3,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 2,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 3,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    0,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    5,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 4,    0,    1, cbra_pkg::ST_NO_SPACE,  0, 6},
    '{0, 0,    cbra_pkg::OP_FREE,  0,    1,    0, cbra_pkg::ST_OK,        0, 0},
    '{0, 0,    cbra_pkg::OP_ALLOC, 2,    0,    0, cbra_pkg::ST_OK,        0, 0}
  };

  localparam int PHASE_CNT = 8;
  localparam phase_t PHASES [PHASE_CNT] = '{
    '{16,   IDLE_NONE, 140},
    '{64,   IDLE_SRC,  150},
    '{1,    IDLE_RCV,  40},
    '{1024, IDLE_BOTH, 110},
    '{37,   IDLE_BOTH, 150},
    '{2047, IDLE_NONE, 70},
    '{8,    IDLE_RCV,  130},
    '{200,  IDLE_SRC,  60}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [10:0]    cfg_wdata = '0;
  logic           req_valid = 1'b0;
  logic           req_stall;
  cbra_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  cbra_pkg::rsp_t rsp;

  logic           cur_typed = 1'b0;
  cbra_pkg::rsp_t cur_exp = '0;
  int             src_pct = 0;
  int             rcv_pct = 0;
  int             errors = 0;
  int             items_sent = 0;
  int             results_seen = 0;
  int             grants = 0;

  logic [1:0]     slot_mark [1024];
  int             pool_free;
  int             pool_hint;
  int             pool_len;
  pending_t       awaited_rsp [$];
  logic [9:0]     live_runs [$];

  chained_bitmap_range_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void pool_reset(input logic [10:0] v);
    pool_len = (v == 0) ? 1 : ((v > 1024) ? 1024 : int'(v));
    foreach (slot_mark[i]) slot_mark[i] = 2'b00;
    pool_free = pool_len;
    pool_hint = 0;
  endfunction

  function automatic cbra_pkg::rsp_t pool_apply(input cbra_pkg::req_t q);
    cbra_pkg::rsp_t o;
    int   cnt;
    int   idx;
    int   k;
    bit   found;
    o = '0;
    cnt = int'(q.slot_count);
    idx = int'(q.start_slot);
    if (q.op == cbra_pkg::OP_ALLOC) begin
      if (cnt == 0) begin
        o.status = cbra_pkg::ST_ZERO_CNT;
      end else if (cnt > pool_free || cnt > pool_len) begin
        o.status = cbra_pkg::ST_NO_SPACE;
      end else begin
        idx = pool_hint;
        found = 1'b0;
        while (!found && idx + cnt <= pool_len) begin
          found = 1'b1;
          k = 0;
          while (found && k < cnt) begin
            if (slot_mark[idx + k][cbra_pkg::MARK_ALLOC]) begin
              found = 1'b0;
              idx = idx + k + 1;
            end
            k++;
          end
        end
        if (!found) begin
          o.status = cbra_pkg::ST_NO_SPACE;
        end else begin
          for (k = 0; k < cnt; k++) begin
            slot_mark[idx + k][cbra_pkg::MARK_ALLOC] = 1'b1;
            slot_mark[idx + k][cbra_pkg::MARK_CHAIN] = (k + 1 < cnt);
          end
          pool_free -= cnt;
          if (idx == pool_hint) begin
            k = idx + cnt;
            while (k < pool_len && slot_mark[k][cbra_pkg::MARK_ALLOC]) k++;
            pool_hint = k;
          end
          o.status = cbra_pkg::ST_OK;
          o.granted_start = idx[9:0];
        end
      end
    end else if (idx >= pool_len) begin
      o.status = cbra_pkg::ST_BAD_START;
    end else begin
      k = idx;
      found = 1'b1;
      while (found && k < pool_len) begin
        slot_mark[k][cbra_pkg::MARK_ALLOC] = 1'b0;
        if (pool_free < pool_len) pool_free++;
        found = slot_mark[k][cbra_pkg::MARK_CHAIN];
        k++;
      end
      if (idx < pool_hint) pool_hint = idx;
      o.status = cbra_pkg::ST_OK;
    end
    o.free_slots = pool_free[10:0];
    return o;
  endfunction

  task automatic field_chk(input string what, input int want, input logic [10:0] got);
    if (got !== 11'(want)) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic push_item(input cbra_pkg::req_t r, input logic typed, input cbra_pkg::rsp_t e);
    req <= r;
    req_valid <= 1'b1;
    cur_typed <= typed;
    cur_exp <= e;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [10:0] v);
    drain();
    repeat (8) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    pool_reset(v);
    live_runs.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    pending_t p;
    if (!rst && req_valid && !req_stall) begin
      p.op = req.op;
      p.r = pool_apply(req);
      if (cur_typed) p.r = cur_exp;
      awaited_rsp.push_back(p);
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (awaited_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
      end else begin
        p = awaited_rsp.pop_front();
        field_chk("status", int'(p.r.status), 11'(rsp.status));
        field_chk("granted_start", int'(p.r.granted_start), 11'(rsp.granted_start));
        field_chk("free_slots", int'(p.r.free_slots), rsp.free_slots);
        if (p.op == cbra_pkg::OP_ALLOC && p.r.status == cbra_pkg::ST_OK) begin
          live_runs.push_back(p.r.granted_start);
          grants++;
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < rcv_pct);
  end

  initial begin
    #(1_000_000_000);
    $display("[chained_bitmap_range_allocator_unit] ERROR");
    $finish;
  end

  initial begin
    cbra_pkg::req_t r;
    cbra_pkg::rsp_t e;
    int   roll;
    int   pick;
    pool_reset(cbra_pkg::RESET_LENGTH);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].is_cfg) begin
        write_length(PLAN[i].cfg_len);
      end else begin
        r.op = PLAN[i].op;
        r.slot_count = PLAN[i].cnt;
        r.start_slot = PLAN[i].start;
        e.status = PLAN[i].st;
        e.granted_start = PLAN[i].gs;
        e.free_slots = PLAN[i].fr;
        push_item(r, PLAN[i].typed, e);
      end
    end

    e = '0;
    for (int ph = 0; ph < PHASE_CNT; ph++) begin
      write_length(PHASES[ph].len);
      case (PHASES[ph].mode)
        IDLE_SRC: begin
          src_pct = 45;
          rcv_pct = 0;
        end
        IDLE_RCV: begin
          src_pct = 0;
          rcv_pct = 45;
        end
        IDLE_BOTH: begin
          src_pct = 19;
          rcv_pct = 19;
        end
        default: begin
          src_pct = 0;
          rcv_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASES[ph].items; n++) begin
        if (PHASES[ph].mode == IDLE_BOTH && n == PHASES[ph].items / 2) drain();
        if (src_pct != 0 && $urandom_range(99) < src_pct) begin
          req_valid <= 1'b0;
          do @(posedge clk); while ($urandom_range(99) < src_pct);
        end
        r.slot_count = 11'($urandom_range(2047, 0));
        r.start_slot = 10'($urandom_range(1023, 0));
        roll = int'($urandom_range(99));
        if (roll < 45) begin
          r.op = cbra_pkg::OP_ALLOC;
          r.slot_count = 11'($urandom_range((pool_len / 4 > 1) ? pool_len / 4 : 1, 1));
        end else if (roll < 55) begin
          r.op = cbra_pkg::OP_ALLOC;
          r.slot_count = 11'($urandom_range(pool_len, 1));
        end else if (roll < 90) begin
          r.op = cbra_pkg::OP_FREE;
          if (live_runs.size() != 0) begin
            pick = int'($urandom_range(live_runs.size() - 1));
            r.start_slot = live_runs[pick];
            live_runs.delete(pick);
          end else begin
            r.start_slot = 10'($urandom_range(pool_len - 1, 0));
          end
        end else if (roll < 95) begin
          r.op = cbra_pkg::OP_ALLOC;
        end else begin
          r.op = cbra_pkg::OP_FREE;
        end
        push_item(r, 1'b0, e);
      end
    end

    drain();
    rcv_pct = 0;
    repeat (40) @(posedge clk);
    $display("Covered %0d items in a directed table and %0d random phases (lengths 1 to 1024).",
             items_sent, PHASE_CNT);
    $display("Checked %0d results, %0d of them granted runs; %0d mismatches.",
             results_seen, grants, errors);
    if (errors == 0 && awaited_rsp.size() == 0) begin
      $display("[chained_bitmap_range_allocator_unit] OK");
    end else begin
      $display("[chained_bitmap_range_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cbra_pkg.sv
rtl/cbra_dpath.sv
rtl/cbra_ctrl.sv
rtl/chained_bitmap_range_allocator_unit.sv
verif/tb_chained_bitmap_range_allocator_unit.sv
